FILE: rtl/core/mdce_pkg.sv
// ----------------------------------------------------------------------------
// mdce_pkg: shared types and constants
// Result codes, descriptor tags and the result record shared by the
// descriptor config extractor modules.
// ----------------------------------------------------------------------------
package mdce_pkg;

    localparam int LENGTH_BITS_DEFAULT = 28;
    localparam int PAYLOAD_LEN_W       = 28;
    localparam int BYTE_W              = 8;
    localparam int KIND_W              = 2;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FINAL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL    = 2'd2;

    localparam logic [BYTE_W-1:0] TAG_ES_DESC   = 8'h03;
    localparam logic [BYTE_W-1:0] TAG_DEC_CFG   = 8'h04;
    localparam logic [BYTE_W-1:0] TAG_DEC_SPEC  = 8'h05;

    localparam logic [BYTE_W-1:0] SKIP_PAIR     = 8'd2;
    localparam logic [BYTE_W-1:0] SKIP_DEC_CFG  = 8'd13;

    typedef struct packed {
        logic [PAYLOAD_LEN_W-1:0] len;
        logic [KIND_W-1:0]        kind;
        logic [BYTE_W-1:0]        data;
    } res_t;

endpackage

FILE: rtl/core/mdce_parser.sv
// ----------------------------------------------------------------------------
// mdce_parser: descriptor parse state machine
// Consumes one blob byte per advance, updates the parse state and forms
// at most one result for that byte.
// ----------------------------------------------------------------------------
module mdce_parser #(
    parameter int LENGTH_BITS = mdce_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [mdce_pkg::BYTE_W-1:0] in_byte,
    input  logic                        in_last,
    output logic                        res_valid,
    output mdce_pkg::res_t              res
);
    import mdce_pkg::*;

    typedef enum logic [3:0] {
        PH_TAG,
        PH_SIZE,
        PH_ES_PRE,
        PH_ES_FLAGS,
        PH_ES_SKIP,
        PH_ES_COUNT,
        PH_DC_SKIP,
        PH_IN_TAG,
        PH_IN_SIZE,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [BYTE_W-1:0]        tag_reg, tag_next;
    logic [LENGTH_BITS-1:0]   acc_reg, acc_next;
    logic [BYTE_W-1:0]        skip_reg, skip_next;
    logic [2:0]               flags_reg, flags_next;
    logic [LENGTH_BITS-1:0]   emit_reg, emit_next;
    logic                     fin_reg, fin_next;

    logic [LENGTH_BITS-1:0]   acc_shift;
    logic [LENGTH_BITS-1:0]   emit_inc;
    logic [BYTE_W-1:0]        skip_dec;
    logic                     size_more;

    logic [2:0]               flags_in;
    logic [2:0]               es_flags;
    phase_t                   es_phase;
    logic                     es_load;

    logic [LENGTH_BITS-1:0]   res_len;
    logic [LENGTH_BITS+PAYLOAD_LEN_W-1:0] len_ext;

    assign acc_shift = {acc_reg[LENGTH_BITS-8:0], in_byte[6:0]};
    assign emit_inc  = emit_reg + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    assign skip_dec  = skip_reg - 8'd1;
    assign size_more = in_byte[7] && !in_last;
    assign flags_in  = (phase_reg == PH_ES_FLAGS) ? in_byte[7:5] : flags_reg;

    // next step of the optional ES fields
    always_comb
    begin
        es_flags = 3'b000;
        es_phase = PH_TAG;
        es_load  = 1'b0;
        if (flags_in[2])
        begin
            es_flags = {1'b0, flags_in[1:0]};
            es_phase = PH_ES_SKIP;
            es_load  = 1'b1;
        end
        else if (flags_in[1])
        begin
            es_flags = {2'b00, flags_in[0]};
            es_phase = PH_ES_COUNT;
        end
        else if (flags_in[0])
        begin
            es_phase = PH_ES_SKIP;
            es_load  = 1'b1;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        acc_next   = acc_reg;
        skip_next  = skip_reg;
        flags_next = flags_reg;
        emit_next  = emit_reg;
        fin_next   = fin_reg;
        res_valid  = 1'b0;
        res.data   = '0;
        res.kind   = KIND_PAYLOAD;
        res_len    = '0;

        case (phase_reg)
            PH_TAG, PH_IN_TAG:
            begin
                tag_next   = in_byte;
                acc_next   = '0;
                phase_next = (phase_reg == PH_TAG) ? PH_SIZE : PH_IN_SIZE;
            end
            PH_SIZE, PH_IN_SIZE:
            begin
                acc_next = acc_shift;
                if (!size_more)
                begin
                    if (phase_reg == PH_SIZE)
                    begin
                        if (tag_reg == TAG_ES_DESC)
                        begin
                            skip_next  = SKIP_PAIR;
                            phase_next = PH_ES_PRE;
                        end
                        else if (tag_reg == TAG_DEC_CFG)
                        begin
                            skip_next  = SKIP_DEC_CFG;
                            phase_next = PH_DC_SKIP;
                        end
                        else
                        begin
                            phase_next = PH_TAG;
                        end
                    end
                    else if (tag_reg == TAG_DEC_SPEC)
                    begin
                        emit_next = '0;
                        if (acc_shift == '0)
                        begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_FAIL;
                            fin_next   = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                    end
                end
            end
            PH_ES_PRE:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = PH_ES_FLAGS;
                end
            end
            PH_ES_FLAGS:
            begin
                flags_next = es_flags;
                phase_next = es_phase;
                if (es_load)
                begin
                    skip_next = SKIP_PAIR;
                end
            end
            PH_ES_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    flags_next = es_flags;
                    phase_next = es_phase;
                    if (es_load)
                    begin
                        skip_next = SKIP_PAIR;
                    end
                end
            end
            PH_ES_COUNT:
            begin
                skip_next = in_byte;
                if (in_byte == '0)
                begin
                    flags_next = es_flags;
                    phase_next = es_phase;
                    if (es_load)
                    begin
                        skip_next = SKIP_PAIR;
                    end
                end
                else
                begin
                    phase_next = PH_ES_SKIP;
                end
            end
            PH_DC_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = PH_IN_TAG;
                end
            end
            PH_PAYLOAD:
            begin
                emit_next = emit_inc;
                if (emit_inc == acc_reg)
                begin
                    res_valid  = 1'b1;
                    res.data   = in_byte;
                    res.kind   = KIND_FINAL;
                    res_len    = acc_reg;
                    fin_next   = 1'b1;
                    phase_next = PH_DONE;
                end
                else if (!in_last)
                begin
                    res_valid = 1'b1;
                    res.data  = in_byte;
                    res.kind  = KIND_PAYLOAD;
                    res_len   = acc_reg;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // end of blob: fail if nothing final went out, then clear
        if (in_last)
        begin
            if (!fin_next)
            begin
                res_valid = 1'b1;
                res.data  = '0;
                res.kind  = KIND_FAIL;
                res_len   = '0;
            end
            phase_next = PH_TAG;
            tag_next   = '0;
            acc_next   = '0;
            skip_next  = '0;
            flags_next = '0;
            emit_next  = '0;
            fin_next   = 1'b0;
        end

        len_ext = {{PAYLOAD_LEN_W{1'b0}}, res_len};
        res.len = len_ext[PAYLOAD_LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            tag_reg   <= '0;
            acc_reg   <= '0;
            skip_reg  <= '0;
            flags_reg <= '0;
            emit_reg  <= '0;
            fin_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            acc_reg   <= acc_next;
            skip_reg  <= skip_next;
            flags_reg <= flags_next;
            emit_reg  <= emit_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

FILE: rtl/core/mdce_out_fifo.sv
// ----------------------------------------------------------------------------
// mdce_out_fifo: two-entry result buffer
// Holds finished results so the parser keeps taking requests while the
// downstream side stalls, until both entries are full.
// ----------------------------------------------------------------------------
module mdce_out_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  mdce_pkg::res_t wr_data,
    output logic           full,
    output logic           rd_valid,
    input  logic           rd_ready,
    output mdce_pkg::res_t rd_data
);
    import mdce_pkg::*;

    res_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       rd_en;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/mpeg4_descriptor_config_extractor_unit.sv
// ----------------------------------------------------------------------------
// mpeg4_descriptor_config_extractor_unit: descriptor config extractor
// Parses an MPEG-4 descriptor blob byte by byte and streams out the
// decoder specific info payload, or a failure result.
// ----------------------------------------------------------------------------
// Results: a request is held in the input register, parsed, and its result, if any,
//   written to the result buffer. Throughput: one request per cycle while the result
//   buffer is not full; the parse step for a byte is a single state machine pass.
// Reset: rst_n clears the parse state and both buffers; the next byte is
//   taken as the first tag byte of a new blob.
module mpeg4_descriptor_config_extractor_unit #(
    parameter int LENGTH_BITS = mdce_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] out_byte, [35:8] payload_length, [39:36] zero
    output logic [1:0]  m_tuser    // [1:0] out_kind
);
    import mdce_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              s_accept;
    logic              advance;
    logic              fifo_full;
    logic              res_valid;
    res_t              res;
    res_t              out_res;

    assign advance  = in_valid_reg && !fifo_full;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    mdce_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    mdce_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (advance && res_valid),
        .wr_data  (res),
        .full     (fifo_full),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_res)
    );

    assign m_tdata = {4'b0000, out_res.len, out_res.data};
    assign m_tuser = out_res.kind;

endmodule

FILE: rtl/core/mdce_checker.sv
// ----------------------------------------------------------------------------
// mdce_checker: port-level checks
// Watches the result stream of the descriptor config extractor.
// ----------------------------------------------------------------------------
module mdce_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import mdce_pkg::*;

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result offered during reset");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_FAIL) |-> (m_tdata == 40'd0))
        else $error("failure result carries data");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind mpeg4_descriptor_config_extractor_unit mdce_checker u_mdce_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
